// ===== design/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication failed");

`endif

// ===== design/ssq_pkg.sv =====
`default_nettype none
package ssq_pkg;

   localparam int QUEUE_DEPTH = 16;

   localparam int IDX_W    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W    = $clog2(QUEUE_DEPTH + 1);
   localparam int POS_W    = $clog2(2 * QUEUE_DEPTH);
   localparam int TIME_W   = 64;
   localparam int ID_W     = 8;
   localparam int DUR_W    = 32;
   localparam int TICK_W   = 63;
   localparam int KIND_W   = 2;
   localparam int STATUS_W = 2;

   localparam int REQ_TDATA_W    = ((ID_W + DUR_W + 7) / 8) * 8;
   localparam int RSP_ID_LSB     = 0;
   localparam int RSP_STATUS_LSB = RSP_ID_LSB + ID_W;
   localparam int RSP_TICK_LSB   = RSP_STATUS_LSB + STATUS_W;
   localparam int RSP_QC_LSB     = RSP_TICK_LSB + TICK_W;
   localparam int RSP_USED_W     = RSP_QC_LSB + CNT_W;
   localparam int RSP_TDATA_W    = ((RSP_USED_W + 7) / 8) * 8;

   typedef enum logic {
      ACTION_TICK  = 1'b0,
      ACTION_SLEEP = 1'b1
   } action_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_IDLE_TICK = 2'd0,
      KIND_WOKEN     = 2'd1,
      KIND_ANSWER    = 2'd2
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_QUEUED  = 2'd0,
      STATUS_IGNORED = 2'd1,
      STATUS_FULL    = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INS_READ,
      ST_INS_CMP,
      ST_TICK_READ,
      ST_TICK_CMP,
      ST_RESPOND
   } state_type;

   typedef struct packed {
      logic [TIME_W-1:0] wake;
      logic [ID_W-1:0]   id;
   } entry_type;

   typedef struct packed {
      kind_type          kind;
      logic [ID_W-1:0]   woken_id;
      status_type        status;
      logic [TICK_W-1:0] tick_count;
      logic [CNT_W-1:0]  queue_count;
      logic              last;
   } rsp_type;

endpackage
`default_nettype wire

// ===== design/ssq_engine.sv =====
`default_nettype none
module ssq_engine (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire ssq_pkg::action_type    req_action,
   input  wire logic [ssq_pkg::ID_W-1:0]  req_id,
   input  wire logic [ssq_pkg::DUR_W-1:0] req_dur,
   output logic                        emit_valid,
   output ssq_pkg::rsp_type            emit_data,
   input  wire logic                   emit_ready
);

   ssq_pkg::state_type state_ff, state_in;
   logic [ssq_pkg::TIME_W-1:0] tick_ff, tick_in;
   logic [ssq_pkg::IDX_W-1:0]  head_ff, head_in;
   logic [ssq_pkg::CNT_W-1:0]  count_ff, count_in;
   logic                       pend_ff, pend_in;
   logic [ssq_pkg::CNT_W-1:0]  k_ff, k_in;
   logic [ssq_pkg::TIME_W-1:0] when_ff, when_in;
   logic [ssq_pkg::ID_W-1:0]   id_ff, id_in;
   logic [ssq_pkg::ID_W-1:0]   pend_id_ff, pend_id_in;
   ssq_pkg::status_type        status_ff, status_in;

   ssq_pkg::entry_type mem [ssq_pkg::QUEUE_DEPTH];
   ssq_pkg::entry_type rd_ff;
   ssq_pkg::entry_type wd;
   logic [ssq_pkg::IDX_W-1:0] wa, ra;
   logic we, re;

   logic accept, full, due, ins_here;
   logic [ssq_pkg::TIME_W:0] when_sum;
   logic [ssq_pkg::IDX_W:0]  head_next;

   function automatic logic [ssq_pkg::IDX_W-1:0] phys(
      input logic [ssq_pkg::IDX_W-1:0] head,
      input logic [ssq_pkg::CNT_W-1:0] k
   );
      logic [ssq_pkg::POS_W-1:0] s;
      s = ssq_pkg::POS_W'(head) + ssq_pkg::POS_W'(k);
      if (s >= ssq_pkg::POS_W'(ssq_pkg::QUEUE_DEPTH)) begin
         s = s - ssq_pkg::POS_W'(ssq_pkg::QUEUE_DEPTH);
      end
      return s[ssq_pkg::IDX_W-1:0];
   endfunction

   assign req_ready = (state_ff == ssq_pkg::ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign full      = (count_ff >= ssq_pkg::CNT_W'(ssq_pkg::QUEUE_DEPTH));
   assign due       = (rd_ff.wake <= tick_ff);
   assign ins_here  = (rd_ff.wake <= when_ff);
   assign when_sum  = {1'b0, tick_ff} +
                      (ssq_pkg::TIME_W + 1)'(req_dur[ssq_pkg::DUR_W-2:0]);
   assign head_next = (ssq_pkg::IDX_W + 1)'(head_ff) + 1'b1;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ssq_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_action == ssq_pkg::ACTION_TICK) begin
                  state_in = ssq_pkg::ST_TICK_READ;
               end else if (req_dur[ssq_pkg::DUR_W-1] || full) begin
                  state_in = ssq_pkg::ST_RESPOND;
               end else begin
                  state_in = ssq_pkg::ST_INS_READ;
               end
            end
         end
         ssq_pkg::ST_INS_READ: begin
            state_in = (k_ff == '0) ? ssq_pkg::ST_RESPOND : ssq_pkg::ST_INS_CMP;
         end
         ssq_pkg::ST_INS_CMP: begin
            state_in = ins_here ? ssq_pkg::ST_RESPOND : ssq_pkg::ST_INS_READ;
         end
         ssq_pkg::ST_TICK_READ: begin
            if (count_ff != '0) begin
               state_in = ssq_pkg::ST_TICK_CMP;
            end else if (emit_ready) begin
               state_in = ssq_pkg::ST_IDLE;
            end
         end
         ssq_pkg::ST_TICK_CMP: begin
            if (!due) begin
               if (emit_ready) begin
                  state_in = ssq_pkg::ST_IDLE;
               end
            end else if (!pend_ff || emit_ready) begin
               state_in = ssq_pkg::ST_TICK_READ;
            end
         end
         ssq_pkg::ST_RESPOND: begin
            if (emit_ready) begin
               state_in = ssq_pkg::ST_IDLE;
            end
         end
         default: state_in = ssq_pkg::ST_IDLE;
      endcase
   end

   // datapath, memory control and result
   always_comb begin
      tick_in    = tick_ff;
      head_in    = head_ff;
      count_in   = count_ff;
      pend_in    = pend_ff;
      k_in       = k_ff;
      when_in    = when_ff;
      id_in      = id_ff;
      pend_id_in = pend_id_ff;
      status_in  = status_ff;
      we         = 1'b0;
      re         = 1'b0;
      wa         = phys(head_ff, k_ff);
      ra         = head_ff;
      wd         = '{wake: when_ff, id: id_ff};
      emit_valid = 1'b0;
      emit_data.kind        = ssq_pkg::KIND_IDLE_TICK;
      emit_data.woken_id    = '0;
      emit_data.status      = ssq_pkg::STATUS_QUEUED;
      emit_data.tick_count  = tick_ff[ssq_pkg::TICK_W-1:0];
      emit_data.queue_count = count_ff;
      emit_data.last        = 1'b1;
      if (pend_ff) begin
         emit_data.kind     = ssq_pkg::KIND_WOKEN;
         emit_data.woken_id = pend_id_ff;
      end
      case (state_ff)
         ssq_pkg::ST_IDLE: begin
            if (accept) begin
               id_in   = req_id;
               k_in    = count_ff;
               pend_in = 1'b0;
               when_in = when_sum[ssq_pkg::TIME_W] ? '1 : when_sum[ssq_pkg::TIME_W-1:0];
               if (req_action == ssq_pkg::ACTION_TICK) begin
                  tick_in = tick_ff + 1'b1;
               end else if (req_dur[ssq_pkg::DUR_W-1]) begin
                  status_in = ssq_pkg::STATUS_IGNORED;
               end else if (full) begin
                  status_in = ssq_pkg::STATUS_FULL;
               end else begin
                  status_in = ssq_pkg::STATUS_QUEUED;
               end
            end
         end
         ssq_pkg::ST_INS_READ: begin
            if (k_ff == '0) begin
               we       = 1'b1;
               count_in = count_ff + 1'b1;
            end else begin
               re = 1'b1;
               ra = phys(head_ff, k_ff - 1'b1);
            end
         end
         ssq_pkg::ST_INS_CMP: begin
            we = 1'b1;
            if (ins_here) begin
               count_in = count_ff + 1'b1;
            end else begin
               wd   = rd_ff;
               k_in = k_ff - 1'b1;
            end
         end
         ssq_pkg::ST_TICK_READ: begin
            if (count_ff != '0) begin
               re = 1'b1;
            end else begin
               emit_valid = 1'b1;
            end
         end
         ssq_pkg::ST_TICK_CMP: begin
            if (!due) begin
               emit_valid = 1'b1;
            end else begin
               emit_valid     = pend_ff;
               emit_data.last = 1'b0;
               if (!pend_ff || emit_ready) begin
                  pend_in    = 1'b1;
                  pend_id_in = rd_ff.id;
                  count_in   = count_ff - 1'b1;
                  head_in    = (head_next == (ssq_pkg::IDX_W + 1)'(ssq_pkg::QUEUE_DEPTH)) ?
                               '0 : head_next[ssq_pkg::IDX_W-1:0];
               end
            end
         end
         ssq_pkg::ST_RESPOND: begin
            emit_valid         = 1'b1;
            emit_data.kind     = ssq_pkg::KIND_ANSWER;
            emit_data.woken_id = '0;
            emit_data.status   = status_ff;
         end
         default: begin
            emit_valid = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ssq_pkg::ST_IDLE;
         tick_ff  <= '0;
         head_ff  <= '0;
         count_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         tick_ff  <= tick_in;
         head_ff  <= head_in;
         count_ff <= count_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff       <= k_in;
      when_ff    <= when_in;
      id_ff      <= id_in;
      pend_id_ff <= pend_id_in;
      status_ff  <= status_in;
   end

   // queue store, one write and one registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[wa] <= wd;
      end
      if (re) begin
         rd_ff <= mem[ra];
      end
   end

endmodule
`default_nettype wire

// ===== design/ssq_out_reg.sv =====
`default_nettype none
module ssq_out_reg (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   output logic                  in_ready,
   input  wire ssq_pkg::rsp_type in_data,
   output logic                  out_valid,
   input  wire logic             out_ready,
   output ssq_pkg::rsp_type      out_data
);

   logic             valid_ff, valid_in;
   ssq_pkg::rsp_type data_ff;
   logic             load;

   assign in_ready  = !valid_ff || out_ready;
   assign load      = in_valid && in_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= in_data;
      end
   end

endmodule
`default_nettype wire

// ===== design/sorted_sleep_wakeup_queue_unit.sv =====
// sorted sleep wake-up queue, timer alarm clock style
//
// req channel: one request per handshake. req_tuser selects a tick (0) or a
// sleep request (1); req_tdata carries sleeper id and a signed duration.
// rsp channel: rsp_tuser gives the result kind, rsp_tlast marks the final
// result of a request. a sleep request gives one answer; a tick gives one
// result per woken sleeper, earliest first, or one empty result.
// sleepers sit in a ring store in wake-time order; inserts walk from the
// tail, moving each later entry up one place with a read and a compare step.
// req_tready is high only while no request is in work, one at a time.
// a rejected or ignored sleep request goes straight to its answer; a queued
// one reads and compares each entry that wakes later, moving it up, then
// writes the new entry and answers. a tick on an empty queue answers
// directly; else it reads and compares the head entry, and each woken sleeper
// takes one such read and compare before the next entry is looked at.
// req_tready returns the cycle after the last result of a request enters the
// output register, so a new request waits until the last one is through.
// results wait in a one-deep output register; when the receiver stalls the
// engine holds its state until the register frees, nothing is dropped.
// reset clears the tick counter and empties the queue at once.
`default_nettype none
module sorted_sleep_wakeup_queue_unit (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // sleeper_id, sleep_duration
   input  wire logic [ssq_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // action
   input  wire logic                              req_tuser,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // woken_id, request_status, tick_count, queue_count, zero fill
   output logic [ssq_pkg::RSP_TDATA_W-1:0]        rsp_tdata,
   // kind
   output logic [ssq_pkg::KIND_W-1:0]             rsp_tuser,
   output logic                                   rsp_tlast
);

   logic             emit_valid, emit_ready;
   ssq_pkg::rsp_type emit_data, rsp_data;

   ssq_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_action (ssq_pkg::action_type'(req_tuser)),
      .req_id     (req_tdata[ssq_pkg::ID_W-1:0]),
      .req_dur    (req_tdata[ssq_pkg::ID_W +: ssq_pkg::DUR_W]),
      .emit_valid (emit_valid),
      .emit_data  (emit_data),
      .emit_ready (emit_ready)
   );

   ssq_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (emit_valid),
      .in_ready  (emit_ready),
      .in_data   (emit_data),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_data)
   );

   assign rsp_tdata = ssq_pkg::RSP_TDATA_W'({rsp_data.queue_count, rsp_data.tick_count,
                                             rsp_data.status, rsp_data.woken_id});
   assign rsp_tuser = rsp_data.kind;
   assign rsp_tlast = rsp_data.last;

endmodule
`default_nettype wire

// ===== design/ssq_checker.sv =====
`default_nettype none
`include "assert_macros.svh"
module ssq_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            rsp_tvalid,
   input wire logic                            rsp_tready,
   input wire logic [ssq_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input wire logic [ssq_pkg::KIND_W-1:0]      rsp_tuser,
   input wire logic                            rsp_tlast
);

   logic answer, idle_tick;

   assign answer    = rsp_tvalid && (rsp_tuser == ssq_pkg::KIND_ANSWER);
   assign idle_tick = rsp_tvalid && (rsp_tuser == ssq_pkg::KIND_IDLE_TICK);

   // a sleep request answer is always a single result
   `ASSERT_IMPL(a_answer_last, clock, reset, answer, rsp_tlast)

   // an empty tick carries no id and closes the request
   `ASSERT_IMPL(a_idle_tick, clock, reset, idle_tick,
                rsp_tlast && (rsp_tdata[ssq_pkg::RSP_ID_LSB +: ssq_pkg::ID_W] == '0))

   // queue never reports more than its depth
   `ASSERT_IMPL(a_count_bound, clock, reset, rsp_tvalid,
                rsp_tdata[ssq_pkg::RSP_QC_LSB +: ssq_pkg::CNT_W] <=
                ssq_pkg::CNT_W'(ssq_pkg::QUEUE_DEPTH))

   // stalled result holds
   `ASSERT_NEXT(a_stall_hold, clock, reset, rsp_tvalid && !rsp_tready,
                rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))

endmodule

bind sorted_sleep_wakeup_queue_unit ssq_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
`default_nettype wire

// ===== verif/sorted_sleep_wakeup_queue_unit_tb.sv =====
`default_nettype none
module sorted_sleep_wakeup_queue_unit_tb;
   import ssq_pkg::*;

   localparam int HOLD_OFF_CYCLES = 300;
   localparam int SETTLE_CYCLES   = 60;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic                   req_tuser  = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [KIND_W-1:0]      rsp_tuser;
   logic                   rsp_tlast;

   sorted_sleep_wakeup_queue_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   // alarm clock mirror
   logic [TIME_W-1:0] ticks_now;
   logic [TIME_W-1:0] wake_at [QUEUE_DEPTH];
   logic [ID_W-1:0]   sleeper_at [QUEUE_DEPTH];
   int unsigned       queued;
   rsp_type           pending_results [$];

   int unsigned error_count     = 0;
   int unsigned requests_sent   = 0;
   int unsigned results_checked = 0;
   int unsigned wakes_seen      = 0;
   int unsigned full_rejects    = 0;
   int unsigned ignored_sleeps  = 0;
   int unsigned far_sleepers    = 0;

   logic        req_jitter      = 1'b0;
   logic        rsp_jitter      = 1'b0;
   int unsigned hold_off_ticket = 0;
   int unsigned hold_off_seen   = 0;
   int unsigned rsp_hold        = 0;

   task automatic expect_result(input kind_type kind, input logic [ID_W-1:0] id,
                                input status_type status, input logic last);
      rsp_type r;
      r.kind        = kind;
      r.woken_id    = id;
      r.status      = status;
      r.tick_count  = ticks_now[TICK_W-1:0];
      r.queue_count = queued[CNT_W-1:0];
      r.last        = last;
      pending_results.push_back(r);
   endtask

   task automatic predict_sleep(input logic [ID_W-1:0] id, input logic [DUR_W-1:0] dur);
      logic [TIME_W-1:0] wake;
      int unsigned       pos;
      int unsigned       i;
      if (dur[DUR_W-1]) begin
         ignored_sleeps++;
         expect_result(KIND_ANSWER, '0, STATUS_IGNORED, 1'b1);
      end else if (queued >= QUEUE_DEPTH) begin
         full_rejects++;
         expect_result(KIND_ANSWER, '0, STATUS_FULL, 1'b1);
      end else begin
         wake = ticks_now + {{(TIME_W-DUR_W){1'b0}}, dur};
         if (wake < ticks_now)
            wake = '1;
         pos = 0;
         while (pos < queued && wake_at[pos] <= wake)
            pos++;
         for (i = queued; i > pos; i--) begin
            wake_at[i]    = wake_at[i-1];
            sleeper_at[i] = sleeper_at[i-1];
         end
         wake_at[pos]    = wake;
         sleeper_at[pos] = id;
         queued++;
         expect_result(KIND_ANSWER, '0, STATUS_QUEUED, 1'b1);
      end
   endtask

   task automatic predict_tick;
      int unsigned due;
      int unsigned total;
      int unsigned i;
      logic [ID_W-1:0] woken [QUEUE_DEPTH];
      ticks_now = ticks_now + 1;
      due = 0;
      while (due < queued && wake_at[due] <= ticks_now)
         due++;
      if (due == 0) begin
         expect_result(KIND_IDLE_TICK, '0, STATUS_QUEUED, 1'b1);
      end else begin
         total = queued;
         for (i = 0; i < due; i++)
            woken[i] = sleeper_at[i];
         for (i = due; i < total; i++) begin
            wake_at[i-due]    = wake_at[i];
            sleeper_at[i-due] = sleeper_at[i];
         end
         for (i = 0; i < due; i++) begin
            queued = total - i - 1;
            expect_result(KIND_WOKEN, woken[i], STATUS_QUEUED, i + 1 == due);
         end
         queued = total - due;
      end
   endtask

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 50)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic send_request(input action_type act, input logic [ID_W-1:0] id,
                               input logic [DUR_W-1:0] dur);
      int unsigned gap;
      gap = req_jitter ? pick_gap() : 0;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {{(REQ_TDATA_W-ID_W-DUR_W){1'b0}}, dur, id};
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      requests_sent++;
      if (act == ACTION_SLEEP)
         predict_sleep(id, dur);
      else
         predict_tick();
   endtask

   task automatic wait_for_results;
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0)
         @(posedge clock);
   endtask

   task automatic report_mismatch(input string what, input logic [TIME_W-1:0] got,
                                  input logic [TIME_W-1:0] want);
      error_count++;
      $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
   endtask

   task automatic check_result;
      rsp_type got;
      rsp_type want;
      got.kind        = kind_type'(rsp_tuser);
      got.woken_id    = rsp_tdata[RSP_ID_LSB +: ID_W];
      got.status      = status_type'(rsp_tdata[RSP_STATUS_LSB +: STATUS_W]);
      got.tick_count  = rsp_tdata[RSP_TICK_LSB +: TICK_W];
      got.queue_count = rsp_tdata[RSP_QC_LSB +: CNT_W];
      got.last        = rsp_tlast;
      if (pending_results.size() == 0) begin
         report_mismatch("result with nothing pending, kind", TIME_W'(got.kind), '0);
      end else begin
         want = pending_results.pop_front();
         results_checked++;
         if (want.kind == KIND_WOKEN)
            wakes_seen++;
         if (got.kind != want.kind)
            report_mismatch("kind", TIME_W'(got.kind), TIME_W'(want.kind));
         if (got.woken_id != want.woken_id)
            report_mismatch("woken id", TIME_W'(got.woken_id), TIME_W'(want.woken_id));
         if (got.status != want.status)
            report_mismatch("status", TIME_W'(got.status), TIME_W'(want.status));
         if (got.tick_count != want.tick_count)
            report_mismatch("tick count", TIME_W'(got.tick_count),
                            TIME_W'(want.tick_count));
         if (got.queue_count != want.queue_count)
            report_mismatch("queue count", TIME_W'(got.queue_count),
                            TIME_W'(want.queue_count));
         if (got.last != want.last)
            report_mismatch("last", TIME_W'(got.last), TIME_W'(want.last));
      end
   endtask

   // result side: checks, random stalls and the long hold-off
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         check_result();
      if (hold_off_seen != hold_off_ticket) begin
         hold_off_seen <= hold_off_ticket;
         rsp_hold      <= HOLD_OFF_CYCLES;
         rsp_tready    <= 1'b0;
      end else if (rsp_hold != 0) begin
         rsp_hold   <= rsp_hold - 1;
         rsp_tready <= 1'b0;
      end else if (rsp_jitter && $urandom_range(0, 3) == 0) begin
         rsp_hold   <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                   : $urandom_range(0, 2);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic test_idle_tick_and_zero_sleep;
      send_request(ACTION_TICK, 8'h00, 32'h0);
      send_request(ACTION_SLEEP, 8'h00, 32'h0);
      send_request(ACTION_TICK, 8'h00, 32'h0);
   endtask

   task automatic test_ignored_and_far_sleeps;
      send_request(ACTION_SLEEP, 8'hFF, 32'h8000_0000);
      send_request(ACTION_SLEEP, 8'h55, 32'hFFFF_FFFF);
      send_request(ACTION_SLEEP, 8'hAA, 32'h7FFF_FFFF);
      far_sleepers++;
   endtask

   task automatic test_equal_wake_order;
      send_request(ACTION_SLEEP, 8'h01, 32'd3);
      send_request(ACTION_SLEEP, 8'h02, 32'd3);
      send_request(ACTION_SLEEP, 8'h03, 32'd1);
      repeat (3) send_request(ACTION_TICK, 8'h00, 32'h0);
   endtask

   task automatic test_queue_full;
      logic [ID_W-1:0] id;
      id = 8'h10;
      while (queued < QUEUE_DEPTH) begin
         send_request(ACTION_SLEEP, id, 32'd1);
         id++;
      end
      send_request(ACTION_SLEEP, 8'hEE, 32'd1);
      send_request(ACTION_TICK, 8'h00, 32'h0);
      // sender waits for every pending result
      wait_for_results();
   endtask

   task automatic test_backpressure;
      int n;
      req_jitter = 1'b0;
      hold_off_ticket <= hold_off_ticket + 1;
      for (n = 0; n < 20; n++) begin
         if (n % 3 == 2)
            send_request(ACTION_TICK, 8'h00, 32'h0);
         else
            send_request(ACTION_SLEEP, 8'($urandom_range(0, 255)), 32'($urandom_range(0, 4)));
      end
      wait_for_results();
   endtask

   task automatic test_random_traffic;
      int n;
      int unsigned pick;
      logic [DUR_W-1:0] dur;
      logic [ID_W-1:0]  id;
      for (n = 0; n < 160; n++) begin
         req_jitter = (n >= 40);
         rsp_jitter <= (n >= 40);
         if (n == 120)
            wait_for_results();
         pick = $urandom_range(0, 99);
         id   = 8'($urandom_range(0, 255));
         if (pick < 45) begin
            send_request(ACTION_TICK, id, $urandom);
         end else begin
            if (pick < 85)
               dur = $urandom_range(0, 12);
            else if (pick < 93)
               dur = $urandom | 32'h8000_0000;
            else if (pick < 97 || far_sleepers >= 3)
               dur = $urandom_range(0, 255);
            else begin
               dur = ($urandom & 32'h7FFF_FFFF) | 32'h4000_0000;
               far_sleepers++;
            end
            send_request(ACTION_SLEEP, id, dur);
         end
      end
   endtask

   initial begin
      ticks_now = '0;
      queued    = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_idle_tick_and_zero_sleep();
      test_ignored_and_far_sleeps();
      test_equal_wake_order();
      test_queue_full();
      rsp_jitter <= 1'b1;
      test_backpressure();
      test_random_traffic();
      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("covered %0d requests and %0d results: %0d sleepers woken,",
               requests_sent, results_checked, wakes_seen);
      $display("%0d full-queue rejections, %0d negative sleeps, %0d errors",
               full_rejects, ignored_sleeps, error_count);
      if (error_count == 0)
         $display("sorted_sleep_wakeup_queue_unit regression: pass");
      else
         $display("sorted_sleep_wakeup_queue_unit regression: fail");
      $finish;
   end

   initial begin
      #20_000_000;
      $display("sorted_sleep_wakeup_queue_unit regression: fail");
      $finish;
   end

endmodule
`default_nettype wire

// ===== sorted_sleep_wakeup_queue_unit.f =====
+incdir+design
design/ssq_pkg.sv
design/ssq_engine.sv
design/ssq_out_reg.sv
design/sorted_sleep_wakeup_queue_unit.sv
design/ssq_checker.sv
verif/sorted_sleep_wakeup_queue_unit_tb.sv
